// ===== hdl/pel_pkg.sv =====
// ----------------------------------------------------------------------------
// pel_pkg: shared types and constants
// Result kinds, fixed output field widths, job selection bits and the
// status bundle of the job queue.
// ----------------------------------------------------------------------------
package pel_pkg;

   // result kinds
   localparam logic KIND_WALL = 1'b0;
   localparam logic KIND_BOX  = 1'b1;

   // fixed widths of result fields
   localparam int INDEX_BITS  = 10;
   localparam int LENGTH_BITS = 25;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // bits of the pending job mask in the front
   localparam int JOB_WALL  = 0;
   localparam int JOB_CLOSE = 1;
   localparam int JOB_BOX   = 2;
   localparam int JOB_COUNT = 3;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/pel_if.sv =====
// ----------------------------------------------------------------------------
// pel_if: request and response channels
// Valid/ready channels carrying one vertex request and one result.
// ----------------------------------------------------------------------------
interface pel_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x_coord;
   logic signed [COORD_BITS-1:0] y_coord;
   logic                         last_vertex;

   modport source (output valid, output x_coord, output y_coord, output last_vertex,
                   input ready);
   modport sink   (input valid, input x_coord, input y_coord, input last_vertex,
                   output ready);
endinterface

interface pel_rsp_if #(parameter int COORD_BITS = 24);
   logic                                   valid;
   logic                                   ready;
   logic                                   kind;
   logic [pel_pkg::INDEX_BITS-1:0]         wall_index;
   logic [pel_pkg::LENGTH_BITS-1:0]        length;
   logic signed [COORD_BITS-1:0]           min_x;
   logic signed [COORD_BITS-1:0]           max_x;
   logic signed [COORD_BITS-1:0]           min_y;
   logic signed [COORD_BITS-1:0]           max_y;
   logic                                   last_result;

   modport source (output valid, output kind, output wall_index, output length,
                   output min_x, output max_x, output min_y, output max_y,
                   output last_result, input ready);
   modport sink   (input valid, input kind, input wall_index, input length,
                   input min_x, input max_x, input min_y, input max_y,
                   input last_result, output ready);
endinterface

// ===== hdl/pel_queue.sv =====
// ----------------------------------------------------------------------------
// pel_queue: small job queue
// Register-based FIFO that decouples the vertex front from the length unit.
// ----------------------------------------------------------------------------
module pel_queue #(
   parameter int WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  logic [WIDTH-1:0]          push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output logic [WIDTH-1:0]          pop_data,
   output pel_pkg::queue_status_type status
);

   localparam int DEPTH = pel_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready   = (count_ff != FULL_COUNT);
   assign pop_valid    = (count_ff != '0);
   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = !push_ready;
   assign status.empty = !pop_valid;

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   // advance pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/pel_front.sv =====
// ----------------------------------------------------------------------------
// pel_front: vertex front end
// Accepts vertices, keeps first/previous vertex, count and running box, and
// issues wall, closing wall and box jobs one per cycle if the queue has room.
// ----------------------------------------------------------------------------
module pel_front #(
   parameter int MAX_WALLS  = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pel_req_if.sink                               req_chan,
   output logic                                  job_valid,
   input  logic                                  job_ready,
   output logic                                  job_kind,
   output logic [$clog2(MAX_WALLS)-1:0]          job_index,
   output logic signed [COORD_BITS-1:0]          job_ax,
   output logic signed [COORD_BITS-1:0]          job_ay,
   output logic signed [COORD_BITS-1:0]          job_bx,
   output logic signed [COORD_BITS-1:0]          job_by
);

   localparam int IW = $clog2(MAX_WALLS);
   localparam int CW = $clog2(MAX_WALLS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_WALLS);
   localparam logic [CW-1:0] INDEX_MAX = CW'(MAX_WALLS - 1);
   localparam int NJ = pel_pkg::JOB_COUNT;

   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_BITS-1:0] old_x_ff, old_x_in, old_y_ff, old_y_in;
   logic signed [COORD_BITS-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [COORD_BITS-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                cur_ff, cur_in;
   logic [NJ-1:0]                mask_ff, mask_in;
   logic                         accept, issue;
   logic [CW-1:0]                wall_idx, close_idx;
   logic signed [COORD_BITS-1:0] vx, vy;

   assign req_chan.ready = (mask_ff == '0);
   assign accept         = req_chan.valid && req_chan.ready;
   assign issue          = job_valid && job_ready;
   assign vx             = req_chan.x_coord;
   assign vy             = req_chan.y_coord;

   // update polygon state on an accepted request
   always_comb begin
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      old_x_in   = old_x_ff;
      old_y_in   = old_y_ff;
      min_x_in   = min_x_ff;
      max_x_in   = max_x_ff;
      min_y_in   = min_y_ff;
      max_y_in   = max_y_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      mask_in    = issue ? (mask_ff & (mask_ff - 1'b1)) : mask_ff;
      if (accept) begin
         old_x_in  = prev_x_ff;
         old_y_in  = prev_y_ff;
         prev_x_in = vx;
         prev_y_in = vy;
         cur_in    = count_ff;
         if (count_ff == '0) begin
            first_x_in = vx;
            first_y_in = vy;
            min_x_in   = vx;
            max_x_in   = vx;
            min_y_in   = vy;
            max_y_in   = vy;
         end else begin
            if (vx < min_x_ff) min_x_in = vx;
            if (vx > max_x_ff) max_x_in = vx;
            if (vy < min_y_ff) min_y_in = vy;
            if (vy > max_y_ff) max_y_in = vy;
         end
         if (req_chan.last_vertex) begin
            count_in = '0;
         end else if (count_ff < COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         mask_in = '0;
         mask_in[pel_pkg::JOB_WALL]  = (count_ff != '0);
         mask_in[pel_pkg::JOB_CLOSE] = req_chan.last_vertex;
         mask_in[pel_pkg::JOB_BOX]   = req_chan.last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         min_x_ff   <= '0;
         max_x_ff   <= '0;
         min_y_ff   <= '0;
         max_y_ff   <= '0;
         count_ff   <= '0;
         mask_ff    <= '0;
      end else begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         min_x_ff   <= min_x_in;
         max_x_ff   <= max_x_in;
         min_y_ff   <= min_y_in;
         max_y_ff   <= max_y_in;
         count_ff   <= count_in;
         mask_ff    <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      old_x_ff <= old_x_in;
      old_y_ff <= old_y_in;
      cur_ff   <= cur_in;
   end

   // wall indexes; the closing wall saturates at the last index
   assign wall_idx  = cur_ff - 1'b1;
   assign close_idx = (cur_ff >= COUNT_MAX) ? INDEX_MAX : cur_ff;

   // issue the lowest pending job
   assign job_valid = (mask_ff != '0);
   always_comb begin
      job_kind  = pel_pkg::KIND_BOX;
      job_index = '0;
      job_ax    = min_x_ff;
      job_ay    = min_y_ff;
      job_bx    = max_x_ff;
      job_by    = max_y_ff;
      if (mask_ff[pel_pkg::JOB_WALL]) begin
         job_kind  = pel_pkg::KIND_WALL;
         job_index = wall_idx[IW-1:0];
         job_ax    = old_x_ff;
         job_ay    = old_y_ff;
         job_bx    = prev_x_ff;
         job_by    = prev_y_ff;
      end else if (mask_ff[pel_pkg::JOB_CLOSE]) begin
         job_kind  = pel_pkg::KIND_WALL;
         job_index = close_idx[IW-1:0];
         job_ax    = prev_x_ff;
         job_ay    = prev_y_ff;
         job_bx    = first_x_ff;
         job_by    = first_y_ff;
      end
   end

endmodule

// ===== hdl/pel_back.sv =====
// ----------------------------------------------------------------------------
// pel_back: length unit
// Takes one job at a time, squares the deltas on a shared multiplier, takes
// a bit-serial integer square root and hands the result to an output register.
// ----------------------------------------------------------------------------
module pel_back #(
   parameter int MAX_WALLS  = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_valid,
   output logic                                  job_ready,
   input  logic                                  job_kind,
   input  logic [$clog2(MAX_WALLS)-1:0]          job_index,
   input  logic signed [COORD_BITS-1:0]          job_ax,
   input  logic signed [COORD_BITS-1:0]          job_ay,
   input  logic signed [COORD_BITS-1:0]          job_bx,
   input  logic signed [COORD_BITS-1:0]          job_by,
   pel_rsp_if.source                             rsp_chan
);

   localparam int CB = COORD_BITS;
   localparam int IW = $clog2(MAX_WALLS);
   localparam int RW = CB + 1;
   localparam int NW = $clog2(RW);
   localparam int XB = pel_pkg::INDEX_BITS;
   localparam int LB = pel_pkg::LENGTH_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQX  = 3'd1;
   localparam logic [2:0] ST_SQY  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_ROOT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic                 kind_ff;
   logic [IW-1:0]        index_ff;
   logic signed [CB-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [CB-1:0]        mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;
   logic [2*CB-1:0]      prod_ff, sq_x_ff, prod_w;
   logic [CB-1:0]        mul_a;
   logic [2*CB:0]        sum_w;
   logic [2*RW-1:0]      rad_ff;
   logic [RW+1:0]        rem_ff, rem_sh, trial;
   logic [RW-1:0]        root_ff;
   logic [NW-1:0]        step_ff;
   logic                 take, load_out;
   logic signed [CB:0]   dx, dy, ndx, ndy;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_kind_ff;
   logic [XB-1:0]        out_index_ff;
   logic [LB-1:0]        out_length_ff;
   logic signed [CB-1:0] out_min_x_ff, out_max_x_ff, out_min_y_ff, out_max_y_ff;
   logic [IW+XB-1:0]     index_wide;
   logic [RW+LB-1:0]     length_wide;

   assign job_ready = (state_ff == ST_IDLE);
   assign take      = job_valid && job_ready;

   // delta magnitudes of the incoming job
   assign dx  = {job_bx[CB-1], job_bx} - {job_ax[CB-1], job_ax};
   assign dy  = {job_by[CB-1], job_by} - {job_ay[CB-1], job_ay};
   assign ndx = -dx;
   assign ndy = -dy;
   assign mag_x_in = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
   assign mag_y_in = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];

   // one shared squarer
   assign mul_a  = (state_ff == ST_SQX) ? mag_x_ff : mag_y_ff;
   assign prod_w = mul_a * mul_a;
   assign sum_w  = {1'b0, sq_x_ff} + {1'b0, prod_ff};

   // one root bit per step
   assign rem_sh = {rem_ff[RW-1:0], rad_ff[2*RW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   assign load_out = (state_ff == ST_DONE) && (!out_valid_ff || rsp_chan.ready);

   // sequence the job
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take) state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_ADD;
         ST_ADD:  state_in = ST_ROOT;
         ST_ROOT: if (step_ff == NW'(RW - 1)) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_valid_in = (out_valid_ff && !rsp_chan.ready) || load_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= job_kind;
         index_ff <= job_index;
         ax_ff    <= job_ax;
         ay_ff    <= job_ay;
         bx_ff    <= job_bx;
         by_ff    <= job_by;
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
      end
      if (state_ff == ST_SQX) begin
         prod_ff <= prod_w;
      end
      if (state_ff == ST_SQY) begin
         sq_x_ff <= prod_ff;
         prod_ff <= prod_w;
      end
      if (state_ff == ST_ADD) begin
         rad_ff  <= {1'b0, sum_w};
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end
      if (state_ff == ST_ROOT) begin
         rad_ff  <= {rad_ff[2*RW-3:0], 2'b00};
         step_ff <= step_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   assign index_wide  = {{XB{1'b0}}, index_ff};
   assign length_wide = {{LB{1'b0}}, root_ff};

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff   <= kind_ff;
         out_index_ff  <= index_wide[XB-1:0];
         out_length_ff <= length_wide[LB-1:0];
         if (kind_ff == pel_pkg::KIND_BOX) begin
            out_min_x_ff <= ax_ff;
            out_min_y_ff <= ay_ff;
            out_max_x_ff <= bx_ff;
            out_max_y_ff <= by_ff;
         end else begin
            out_min_x_ff <= '0;
            out_min_y_ff <= '0;
            out_max_x_ff <= '0;
            out_max_y_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_kind_ff;
   assign rsp_chan.wall_index  = out_index_ff;
   assign rsp_chan.length      = out_length_ff;
   assign rsp_chan.min_x       = out_min_x_ff;
   assign rsp_chan.max_x       = out_max_x_ff;
   assign rsp_chan.min_y       = out_min_y_ff;
   assign rsp_chan.max_y       = out_max_y_ff;
   assign rsp_chan.last_result = (out_kind_ff == pel_pkg::KIND_BOX);

endmodule

// ===== hdl/polygon_edge_length_bbox_unit.sv =====
// ----------------------------------------------------------------------------
// polygon_edge_length_bbox_unit: polygon wall lengths and bounding box
// Measures each wall of a streamed polygon and reports its bounding box.
//
//   channel    direction  payload
//   req_chan   in         x_coord, y_coord, last_vertex
//   rsp_chan   out        kind, wall_index, length, min/max x/y, last_result
//
// The front takes one vertex at a time and queues up to three jobs.
// Each result goes through squaring, adding and a square root in the length
// unit (square root, one bit per cycle); the unit works on one job at a time.
// Synchronous active-high reset clears all control state and the polygon.
// A stalled response holds the output register; the unit keeps working on
// the next job and the front keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module polygon_edge_length_bbox_unit #(
   parameter int MAX_WALLS  = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   pel_req_if.sink    req_chan,
   pel_rsp_if.source  rsp_chan
);

   localparam int CB = COORD_BITS;
   localparam int IW = $clog2(MAX_WALLS);
   localparam int QW = 1 + IW + 4 * CB;

   logic                 f_valid, f_ready, f_kind;
   logic [IW-1:0]        f_index;
   logic signed [CB-1:0] f_ax, f_ay, f_bx, f_by;
   logic                 b_valid, b_ready, b_kind;
   logic [IW-1:0]        b_index;
   logic signed [CB-1:0] b_ax, b_ay, b_bx, b_by;
   logic [QW-1:0]        q_in, q_out;
   pel_pkg::queue_status_type q_status;

   pel_front #(.MAX_WALLS(MAX_WALLS), .COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job_kind  (f_kind),
      .job_index (f_index),
      .job_ax    (f_ax),
      .job_ay    (f_ay),
      .job_bx    (f_bx),
      .job_by    (f_by)
   );

   assign q_in = {f_kind, f_index, f_ax, f_ay, f_bx, f_by};

   pel_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (q_out),
      .status     (q_status)
   );

   assign {b_kind, b_index, b_ax, b_ay, b_bx, b_by} = q_out;

   pel_back #(.MAX_WALLS(MAX_WALLS), .COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (b_valid),
      .job_ready (b_ready),
      .job_kind  (b_kind),
      .job_index (b_index),
      .job_ax    (b_ax),
      .job_ay    (b_ay),
      .job_bx    (b_bx),
      .job_by    (b_by),
      .rsp_chan  (rsp_chan)
   );

   // a last vertex always leaves closing and box jobs pending
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.last_vertex |=> !req_chan.ready)
      else $error("front took a request while closing jobs were pending");

   // box bounds are ordered
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.kind == pel_pkg::KIND_BOX) |->
         (rsp_chan.min_x <= rsp_chan.max_x) && (rsp_chan.min_y <= rsp_chan.max_y))
      else $error("box result with inverted bounds");

   // the queue is never seen full and empty at once
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty) && (q_status.empty == !b_valid))
      else $error("job queue status inconsistent");

endmodule

// ===== tb/sv/polygon_edge_length_bbox_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_edge_length_bbox_checker: wall length and bounding box scoreboard
// Watches the vertex request and result channels of the polygon unit. It
// keeps its own copy of the polygon state, works out the wall and box
// results of every accepted vertex, and compares each accepted result in
// order with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module polygon_edge_length_bbox_checker #(
   parameter int MAX_WALLS  = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [COORD_BITS-1:0]         req_x_coord,
   input  logic signed [COORD_BITS-1:0]         req_y_coord,
   input  logic                                 req_last_vertex,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_kind,
   input  logic [pel_pkg::INDEX_BITS-1:0]       rsp_wall_index,
   input  logic [pel_pkg::LENGTH_BITS-1:0]      rsp_length,
   input  logic signed [COORD_BITS-1:0]         rsp_min_x,
   input  logic signed [COORD_BITS-1:0]         rsp_max_x,
   input  logic signed [COORD_BITS-1:0]         rsp_min_y,
   input  logic signed [COORD_BITS-1:0]         rsp_max_y,
   input  logic                                 rsp_last_result,
   output int                                   fail_count,
   output int                                   pending_results
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                            kind;
      logic [pel_pkg::INDEX_BITS-1:0]  wall_index;
      logic [pel_pkg::LENGTH_BITS-1:0] length;
      logic signed [COORD_BITS-1:0]    min_x;
      logic signed [COORD_BITS-1:0]    max_x;
      logic signed [COORD_BITS-1:0]    min_y;
      logic signed [COORD_BITS-1:0]    max_y;
      logic                            last_result;
   } polygon_result_type;

   polygon_result_type expected_results[$];

   // polygon state mirrored from the unit
   longint start_x, start_y;
   longint prev_x, prev_y;
   longint lo_x, hi_x, lo_y, hi_y;
   int     taken;
   int     fails = 0;

   // floor square root, one result bit at a time from the top
   function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if ({32'd0, trial} * {32'd0, trial} <= n) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // exact floor length between two points in millimetres
   function automatic logic [pel_pkg::LENGTH_BITS-1:0] span_length(
         input longint ax, input longint ay, input longint bx, input longint by);
      longint      dx;
      longint      dy;
      logic [63:0] ux;
      logic [63:0] uy;
      logic [31:0] root;
      dx   = bx - ax;
      dy   = by - ay;
      ux   = (dx < 0) ? -dx : dx;
      uy   = (dy < 0) ? -dy : dy;
      root = floor_sqrt(ux * ux + uy * uy);
      return root[pel_pkg::LENGTH_BITS-1:0];
   endfunction

   // hold the wall index at the last slot once the polygon runs long
   function automatic logic [pel_pkg::INDEX_BITS-1:0] clamp_index(input int idx);
      int limited;
      limited = (idx > MAX_WALLS - 1) ? MAX_WALLS - 1 : idx;
      return limited[pel_pkg::INDEX_BITS-1:0];
   endfunction

   function automatic polygon_result_type make_wall(
         input logic [pel_pkg::INDEX_BITS-1:0] idx,
         input logic [pel_pkg::LENGTH_BITS-1:0] len);
      polygon_result_type w;
      w             = '0;
      w.kind        = pel_pkg::KIND_WALL;
      w.wall_index  = idx;
      w.length      = len;
      w.last_result = 1'b0;
      return w;
   endfunction

   // append one result behind the ones still outstanding
   task automatic queue_result(input polygon_result_type item);
      expected_results.insert(expected_results.size(), item);
   endtask

   // advance the polygon by one vertex and queue the results it causes
   task automatic predict_vertex(input longint x, input longint y, input logic closes);
      polygon_result_type box;
      int                 cur;
      if (taken == 0) begin
         start_x = x;
         start_y = y;
         lo_x    = x;
         hi_x    = x;
         lo_y    = y;
         hi_y    = y;
      end else begin
         queue_result(make_wall(clamp_index(taken - 1), span_length(prev_x, prev_y, x, y)));
         if (x < lo_x) lo_x = x;
         if (x > hi_x) hi_x = x;
         if (y < lo_y) lo_y = y;
         if (y > hi_y) hi_y = y;
      end
      cur    = taken;
      prev_x = x;
      prev_y = y;
      if (taken < MAX_WALLS) begin
         taken++;
      end
      if (closes) begin
         queue_result(make_wall(clamp_index(cur), span_length(x, y, start_x, start_y)));
         box             = '0;
         box.kind        = pel_pkg::KIND_BOX;
         box.wall_index  = '0;
         box.length      = span_length(lo_x, lo_y, hi_x, hi_y);
         box.min_x       = lo_x[COORD_BITS-1:0];
         box.max_x       = hi_x[COORD_BITS-1:0];
         box.min_y       = lo_y[COORD_BITS-1:0];
         box.max_y       = hi_y[COORD_BITS-1:0];
         box.last_result = 1'b1;
         queue_result(box);
         taken = 0;
      end
   endtask

   // watch both channels, predict on requests, compare on results
   always @(posedge clock) begin
      polygon_result_type seen;
      polygon_result_type want;
      if (reset) begin
         expected_results.delete();
         taken   = 0;
         start_x = 0;
         start_y = 0;
         prev_x  = 0;
         prev_y  = 0;
         lo_x    = 0;
         hi_x    = 0;
         lo_y    = 0;
         hi_y    = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_vertex(req_x_coord, req_y_coord, req_last_vertex);
         end
         if (rsp_valid && rsp_ready) begin
            seen.kind        = rsp_kind;
            seen.wall_index  = rsp_wall_index;
            seen.length      = rsp_length;
            seen.min_x       = rsp_min_x;
            seen.max_x       = rsp_max_x;
            seen.min_y       = rsp_min_y;
            seen.max_y       = rsp_max_y;
            seen.last_result = rsp_last_result;
            if (expected_results.size() == 0) begin
               if (fails < REPORT_LIMIT) begin
                  $display("unexpected result: kind=%0d idx=%0d len=%0d last=%0d",
                           seen.kind, seen.wall_index, seen.length, seen.last_result);
               end
               fails++;
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  if (fails < REPORT_LIMIT) begin
                     $display("result mismatch:");
                     $display("  expected kind=%0d idx=%0d len=%0d x=[%0d,%0d] y=[%0d,%0d] last=%0d",
                              want.kind, want.wall_index, want.length,
                              $signed(want.min_x), $signed(want.max_x),
                              $signed(want.min_y), $signed(want.max_y), want.last_result);
                     $display("  actual   kind=%0d idx=%0d len=%0d x=[%0d,%0d] y=[%0d,%0d] last=%0d",
                              seen.kind, seen.wall_index, seen.length,
                              $signed(seen.min_x), $signed(seen.max_x),
                              $signed(seen.min_y), $signed(seen.max_y), seen.last_result);
                  end
                  fails++;
               end
            end
         end
      end
      fail_count      <= fails;
      pending_results <= expected_results.size();
   end

endmodule

// ===== tb/sv/polygon_edge_length_bbox_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_edge_length_bbox_unit_tb: regression for the polygon unit
// Streams directed polygons (extreme corners, one and two vertex shapes,
// repeated points) and random polygons, with random idle bursts on both
// channels. A checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module polygon_edge_length_bbox_unit_tb;

   localparam int MAX_WALLS    = 1024;
   localparam int COORD_BITS   = 24;
   localparam int RANDOM_ITEMS = 192;
   localparam int CALM_ITEMS   = 40;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 600000;

   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   typedef enum int {
      COORD_FULL,
      COORD_NEAR,
      COORD_EDGE
   } coord_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic no_idle;
   int   fail_count;
   int   pending_results;
   int   cycle_count = 0;

   pel_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   pel_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   polygon_edge_length_bbox_unit #(
      .MAX_WALLS (MAX_WALLS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   polygon_edge_length_bbox_checker #(
      .MAX_WALLS (MAX_WALLS),
      .COORD_BITS(COORD_BITS)
   ) result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_x_coord    (req_bus.x_coord),
      .req_y_coord    (req_bus.y_coord),
      .req_last_vertex(req_bus.last_vertex),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_kind       (rsp_bus.kind),
      .rsp_wall_index (rsp_bus.wall_index),
      .rsp_length     (rsp_bus.length),
      .rsp_min_x      (rsp_bus.min_x),
      .rsp_max_x      (rsp_bus.max_x),
      .rsp_min_y      (rsp_bus.min_y),
      .rsp_max_y      (rsp_bus.max_y),
      .rsp_last_result(rsp_bus.last_result),
      .fail_count     (fail_count),
      .pending_results(pending_results)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("polygon_edge_length_bbox_unit regression: fail");
         $finish;
      end
   end

   // result back-pressure: random bursts of stalled cycles, with calm windows
   int   stall_left  = 0;
   int   window_left = 0;
   logic stalls_on   = 1'b0;

   always @(posedge clock) begin
      logic ready_next;
      if (window_left == 0) begin
         window_left = $urandom_range(50, 400);
         stalls_on   = ($urandom_range(0, 2) != 0);
      end else begin
         window_left--;
      end
      if (no_idle) begin
         stall_left = 0;
         ready_next = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
      end
      rsp_bus.ready <= ready_next;
   end

   // pick one coordinate in the given style
   function automatic logic signed [COORD_BITS-1:0] pick_coord(
         input coord_mode_type mode, input logic signed [COORD_BITS-1:0] center);
      logic signed [COORD_BITS-1:0] c;
      case (mode)
         COORD_NEAR: begin
            c = center + COORD_BITS'($urandom_range(0, 4095)) - COORD_BITS'(2048);
         end
         COORD_EDGE: begin
            case ($urandom_range(0, 3))
               0:       c = COORD_MIN;
               1:       c = COORD_MAX;
               2:       c = '0;
               default: c = '1;
            endcase
         end
         default: begin
            c = COORD_BITS'($urandom());
         end
      endcase
      return c;
   endfunction

   // offer one vertex request, with an optional idle burst ahead of it
   task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input logic closes);
      int gap;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.x_coord     <= x;
      req_bus.y_coord     <= y;
      req_bus.last_vertex <= closes;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   initial begin
      int                           sent_random;
      int                           nverts;
      int                           shape;
      coord_mode_type               mode;
      logic signed [COORD_BITS-1:0] center;

      reset               <= 1'b1;
      no_idle             <= 1'b0;
      req_bus.valid       <= 1'b0;
      req_bus.x_coord     <= '0;
      req_bus.y_coord     <= '0;
      req_bus.last_vertex <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single vertex polygons, at the origin and at the corners
      send_vertex('0, '0, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, 1'b1);

      // two vertex polygon across the full diagonal
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1);

      // triangle and square on the extreme coordinates
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex('0, COORD_MAX, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, 1'b1);

      // repeated points give zero length walls
      send_vertex(24'sd5, 24'sd5, 1'b0);
      send_vertex(24'sd5, 24'sd5, 1'b0);
      send_vertex(24'sd5, 24'sd5, 1'b1);

      // exact 3-4-5 walls through the origin
      send_vertex(24'sd3, 24'sd4, 1'b0);
      send_vertex('0, '0, 1'b0);
      send_vertex(-24'sd3, -24'sd4, 1'b1);

      // random polygons, finishing the last one past the item count
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         shape  = $urandom_range(0, 9);
         nverts = (shape == 0) ? 1 : (shape == 1) ? 2 : $urandom_range(3, 12);
         mode   = coord_mode_type'($urandom_range(0, 2));
         center = COORD_BITS'($urandom());
         for (int v = 0; v < nverts; v++) begin
            if (sent_random == RANDOM_ITEMS - CALM_ITEMS) begin
               no_idle <= 1'b1;
            end
            send_vertex(pick_coord(mode, center), pick_coord(mode, center), v == nverts - 1);
            sent_random++;
         end
      end
      req_bus.valid <= 1'b0;

      // drain outstanding results, then give the unit time for strays
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("polygon_edge_length_bbox_unit regression: pass");
      end else begin
         $display("polygon_edge_length_bbox_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/pel_pkg.sv
hdl/pel_if.sv
hdl/pel_queue.sv
hdl/pel_front.sv
hdl/pel_back.sv
hdl/polygon_edge_length_bbox_unit.sv
tb/sv/polygon_edge_length_bbox_checker.sv
tb/sv/polygon_edge_length_bbox_unit_tb.sv
